>>> rtl/qtl_pkg.sv
// Shared types, codes and widths for the quantized transport launch block.
// No dependencies; imported by every module under rtl/.
package qtl_pkg;

    localparam int QUANT_WIDTH   = 23;
    localparam logic [QUANT_WIDTH-1:0] QUANT_RESET = 23'd262144;
    localparam int POS_WIDTH_DEF = 48;
    localparam int OPC_WIDTH     = 2;
    localparam int ACT_WIDTH     = 2;
    localparam int RUN_WIDTH     = 2;
    localparam int RES_WIDTH     = ACT_WIDTH + RUN_WIDTH + 1;
    localparam int M_TDATA_WIDTH = ((RES_WIDTH + 7) / 8) * 8;

    typedef enum logic [OPC_WIDTH-1:0] {
        OPC_NONE    = 2'd0,
        OPC_PLAY    = 2'd1,
        OPC_STOP    = 2'd2,
        OPC_REALIGN = 2'd3
    } qtl_opcode_t;

    typedef enum logic [ACT_WIDTH-1:0] {
        ACT_NONE    = 2'd0,
        ACT_START   = 2'd1,
        ACT_STOP    = 2'd2,
        ACT_RESTART = 2'd3
    } qtl_action_t;

    localparam logic [RUN_WIDTH-1:0] RUN_STOPPED = 2'd0;
    localparam logic [RUN_WIDTH-1:0] RUN_ARMED   = 2'd1;
    localparam logic [RUN_WIDTH-1:0] RUN_RUNNING = 2'd2;

    typedef enum logic [2:0] {
        MODE_STOPPED = 3'b001,
        MODE_ARMED   = 3'b010,
        MODE_RUNNING = 3'b100
    } qtl_mode_t;

    // Everything the transport state needs to decide one item.
    typedef struct packed {
        qtl_opcode_t opcode;
        logic        beat_valid;
        logic        prev_valid;
        logic        on_grid;
        logic        crossed;
    } qtl_eval_t;

    typedef struct packed {
        qtl_action_t           action;
        logic [RUN_WIDTH-1:0]  run_state;
        logic                  realign_pending;
    } qtl_result_t;

    function automatic logic [RUN_WIDTH-1:0] run_code(input qtl_mode_t m);
        logic [RUN_WIDTH-1:0] c;
        unique case (m)
            MODE_STOPPED: c = RUN_STOPPED;
            MODE_ARMED:   c = RUN_ARMED;
            MODE_RUNNING: c = RUN_RUNNING;
            default:      c = RUN_STOPPED;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/quantized_transport_launch_core.sv
// Top level of the quantized transport launch block: stream ports, sequencer, beat history.
// Depends on qtl_pkg, qtl_serial_div and qtl_transport_state.
//
//  channel  | direction | payload                                   | handshake
//  ---------+-----------+-------------------------------------------+------------------
//  s_       | in        | tdata: opcode, beat_position; tuser: valid | tvalid / tready
//  m_       | out       | tdata: action, run_state, realign_pending  | tvalid / tready
//  cfg_     | in        | quantum_length                             | cfg_we, no wait
//
// Each item passes through the two bit-serial dividers, which resolve one quotient bit per cycle,
// and its result is formed once both dividers have finished.
// One item is in work at a time; the next is taken as soon as the previous result has
// moved into the output register, even while that result still waits for m_tready.
// aresetn is synchronous, active low: mode stopped, no pending realign, no beat history,
// quantum back to 4.0 beats. A stall on m_tready holds the finished item in the last step.
module quantized_transport_launch_core #(
    parameter int POS_WIDTH = qtl_pkg::POS_WIDTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,

    input  logic                                 cfg_we,
    input  logic [qtl_pkg::QUANT_WIDTH-1:0]      cfg_wdata,   // quantum_length

    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [1:0] opcode, [POS_WIDTH+1:2] beat_position, rest zero
    input  logic [((qtl_pkg::OPC_WIDTH+POS_WIDTH+7)/8)*8-1:0] s_tdata,
    input  logic                                 s_tuser,     // [0] beat_valid

    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [1:0] action, [3:2] run_state, [4] realign_pending, rest zero
    output logic [qtl_pkg::M_TDATA_WIDTH-1:0]    m_tdata
);
    import qtl_pkg::*;

    typedef enum logic [2:0] {
        SQ_IDLE   = 3'b001,
        SQ_DIV    = 3'b010,
        SQ_FINISH = 3'b100
    } seq_state_t;

    seq_state_t                  seq_reg, seq_next;
    logic [QUANT_WIDTH-1:0]      quantum_reg;
    qtl_opcode_t                 opc_reg;
    logic                        bvalid_reg;
    logic                        pvalid_item_reg;   // history flag seen by this item
    logic [POS_WIDTH-1:0]        prev_pos_reg;
    logic                        prev_valid_reg;
    logic                        m_tvalid_reg;
    logic [M_TDATA_WIDTH-1:0]    m_tdata_reg;

    logic                        accept;
    logic                        out_free;
    logic                        commit;
    logic                        done_now, done_prev;
    logic [POS_WIDTH:0]          floor_now, floor_prev;
    logic                        remz_now, remz_prev;
    logic                        q_zero;
    qtl_eval_t                   ev;
    qtl_result_t                 res;

    assign s_tready = (seq_reg == SQ_IDLE);
    assign accept   = s_tvalid & s_tready;
    assign out_free = ~m_tvalid_reg | m_tready;
    assign commit   = (seq_reg == SQ_FINISH) & out_free;
    assign q_zero   = (quantum_reg == '0);

    // Divide the new beat and the stored beat in lockstep.
    qtl_serial_div #(.W(POS_WIDTH), .QW(QUANT_WIDTH)) u_div_now (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept),
        .dividend (s_tdata[POS_WIDTH+OPC_WIDTH-1:OPC_WIDTH]),
        .divisor  (quantum_reg),
        .done     (done_now),
        .floor_q  (floor_now),
        .rem_zero (remz_now)
    );

    qtl_serial_div #(.W(POS_WIDTH), .QW(QUANT_WIDTH)) u_div_prev (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept),
        .dividend (prev_pos_reg),
        .divisor  (quantum_reg),
        .done     (done_prev),
        .floor_q  (floor_prev),
        .rem_zero (remz_prev)
    );

    // A zero quantum crosses on every tick and never lands on the grid.
    always_comb begin
        ev.opcode     = opc_reg;
        ev.beat_valid = bvalid_reg;
        ev.prev_valid = pvalid_item_reg;
        ev.on_grid    = ~q_zero & remz_now;
        ev.crossed    = q_zero | ($signed(floor_now) > $signed(floor_prev)) | ev.on_grid;
    end

    qtl_transport_state u_state (
        .aclk    (aclk),
        .aresetn (aresetn),
        .commit  (commit),
        .ev      (ev),
        .res     (res)
    );

    always_comb begin
        seq_next = seq_reg;
        unique case (seq_reg)
            SQ_IDLE:   if (accept) seq_next = SQ_DIV;
            SQ_DIV:    if (done_now && done_prev) seq_next = SQ_FINISH;
            SQ_FINISH: if (commit) seq_next = SQ_IDLE;
            default:   seq_next = SQ_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg        <= SQ_IDLE;
            quantum_reg    <= QUANT_RESET;
            prev_valid_reg <= 1'b0;
            prev_pos_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            seq_reg <= seq_next;
            if (cfg_we) quantum_reg <= cfg_wdata;
            // Advance the beat history on every accepted item.
            if (accept) begin
                prev_valid_reg <= 1'b1;
                prev_pos_reg   <= s_tdata[POS_WIDTH+OPC_WIDTH-1:OPC_WIDTH];
            end
            if (commit)        m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
        end
    end

    // Item fields and the result word carry no reset.
    always_ff @(posedge aclk) begin
        if (accept) begin
            opc_reg         <= qtl_opcode_t'(s_tdata[OPC_WIDTH-1:0]);
            bvalid_reg      <= s_tuser;
            pvalid_item_reg <= prev_valid_reg;
        end
        if (commit) begin
            m_tdata_reg <= {{(M_TDATA_WIDTH-RES_WIDTH){1'b0}},
                            res.realign_pending, res.run_state, res.action};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_accept_starts_div: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> seq_reg == SQ_DIV && !done_now)
        else $error("accepted item did not start the dividers");

    a_div_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        done_now == done_prev)
        else $error("dividers out of step");

    a_commit_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> m_tvalid && s_tready)
        else $error("finished item not moved to the output register");

endmodule

>>> rtl/qtl_serial_div.sv
// Bit-serial restoring divider: floor(signed dividend / unsigned divisor) and remainder-zero flag.
// One quotient bit per cycle; depends on qtl_pkg.
module qtl_serial_div #(
    parameter int W  = qtl_pkg::POS_WIDTH_DEF,
    parameter int QW = qtl_pkg::QUANT_WIDTH
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [QW-1:0] divisor,
    output logic         done,
    output logic [W:0]   floor_q,
    output logic         rem_zero
);
    import qtl_pkg::*;

    localparam int CW = $clog2(W);

    typedef enum logic [3:0] {
        D_IDLE  = 4'b0001,
        D_SHIFT = 4'b0010,
        D_FIX   = 4'b0100,
        D_DONE  = 4'b1000
    } div_state_t;

    div_state_t      st_reg, st_next;
    logic [CW-1:0]   cnt_reg;
    logic [QW-1:0]   rem_reg;
    logic [QW-1:0]   div_reg;
    logic [W-1:0]    dvd_reg;
    logic            neg_reg;
    logic [W:0]      quo_reg;
    logic            remz_reg;

    logic [QW+1:0]   trial;
    logic            fits;
    logic [W-1:0]    mag;
    logic [W:0]      q_ext;
    logic [W:0]      fixed_q;

    always_comb begin
        trial   = {1'b0, rem_reg, dvd_reg[W-1]} - {2'b00, div_reg};
        fits    = ~trial[QW+1];
        mag     = dividend[W-1] ? (~dividend + {{(W-1){1'b0}}, 1'b1}) : dividend;
        q_ext   = {1'b0, dvd_reg};
        // negative: floor = -(Q + (rem != 0))
        if (!neg_reg) begin
            fixed_q = q_ext;
        end else if (|rem_reg) begin
            fixed_q = ~q_ext;
        end else begin
            fixed_q = (~q_ext) + {{W{1'b0}}, 1'b1};
        end
    end

    always_comb begin
        st_next = st_reg;
        if (start) begin
            st_next = D_SHIFT;
        end else begin
            unique case (st_reg)
                D_IDLE:  st_next = D_IDLE;
                D_SHIFT: if (cnt_reg == '0) st_next = D_FIX;
                D_FIX:   st_next = D_DONE;
                D_DONE:  st_next = D_DONE;
                default: st_next = D_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= D_IDLE;
        end else begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            cnt_reg <= CW'(W - 1);
            rem_reg <= '0;
            div_reg <= divisor;
            dvd_reg <= mag;
            neg_reg <= dividend[W-1];
        end else if (st_reg == D_SHIFT) begin
            cnt_reg <= cnt_reg - {{(CW-1){1'b0}}, 1'b1};
            rem_reg <= fits ? trial[QW-1:0] : {rem_reg[QW-2:0], dvd_reg[W-1]};
            dvd_reg <= {dvd_reg[W-2:0], fits};
        end else if (st_reg == D_FIX) begin
            quo_reg  <= fixed_q;
            remz_reg <= ~(|rem_reg);
        end
    end

    assign done     = (st_reg == D_DONE);
    assign floor_q  = quo_reg;
    assign rem_zero = remz_reg;

endmodule

>>> rtl/qtl_transport_state.sv
// Transport mode and pending-realign registers with the per-item decision logic.
// Depends on qtl_pkg for codes, the mode enum and the eval/result structs.
module qtl_transport_state (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 commit,
    input  qtl_pkg::qtl_eval_t   ev,
    output qtl_pkg::qtl_result_t res
);
    import qtl_pkg::*;

    qtl_mode_t   mode_reg, mode_next;
    logic        realign_reg, realign_next;
    qtl_action_t action;

    always_comb begin
        mode_next    = mode_reg;
        realign_next = realign_reg;
        action       = ACT_NONE;
        unique case (ev.opcode)
            OPC_STOP: begin
                if (mode_reg == MODE_RUNNING) action = ACT_STOP;
                mode_next    = MODE_STOPPED;
                realign_next = 1'b0;
            end
            OPC_PLAY: begin
                if (mode_reg != MODE_RUNNING) begin
                    if (!ev.beat_valid || ev.on_grid) begin
                        mode_next = MODE_RUNNING;
                        action    = ACT_START;
                    end else begin
                        mode_next = MODE_ARMED;
                    end
                end
            end
            OPC_REALIGN: begin
                if (mode_reg == MODE_RUNNING && ev.beat_valid) begin
                    if (ev.on_grid) action = ACT_RESTART;
                    else            realign_next = 1'b1;
                end
            end
            OPC_NONE: begin
                if (mode_reg == MODE_ARMED) begin
                    if (!ev.beat_valid || (ev.prev_valid && ev.crossed)) begin
                        mode_next = MODE_RUNNING;
                        action    = ACT_START;
                    end
                end else if (realign_reg && mode_reg == MODE_RUNNING) begin
                    if (ev.beat_valid && ev.prev_valid && ev.crossed) begin
                        realign_next = 1'b0;
                        action       = ACT_RESTART;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_STOPPED;
            realign_reg <= 1'b0;
        end else if (commit) begin
            mode_reg    <= mode_next;
            realign_reg <= realign_next;
        end
    end

    assign res.action          = action;
    assign res.run_state       = run_code(mode_next);
    assign res.realign_pending = realign_next;

    a_realign_only_running: assert property (@(posedge aclk) disable iff (!aresetn)
        realign_reg |-> mode_reg == MODE_RUNNING)
        else $error("realign pending outside running mode");

    a_start_enters_running: assert property (@(posedge aclk) disable iff (!aresetn)
        commit && action == ACT_START |=> mode_reg == MODE_RUNNING)
        else $error("start reported without entering running mode");

    a_stop_from_running: assert property (@(posedge aclk) disable iff (!aresetn)
        commit && action == ACT_STOP |-> mode_reg == MODE_RUNNING)
        else $error("stop reported while not running");

endmodule
